### hw/rtl/wfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wfu_pkg;

    // Header byte codes
    localparam logic [7:0] OPC_TEXT_FINAL  = 8'h81;
    localparam logic [7:0] OPC_CLOSE_FINAL = 8'h88;
    localparam logic [7:0] OPC_NIBBLE_MASK = 8'h0F;
    localparam logic [7:0] LEN_CODE_MASK   = 8'h7F;
    localparam logic [7:0] LEN_CODE_16     = 8'd126;
    localparam logic [7:0] LEN_CODE_64     = 8'd127;

    // Frame kinds reported on the result
    localparam logic [3:0] KIND_TEXT  = 4'd1;
    localparam logic [3:0] KIND_CLOSE = 4'd8;

    // Position of the first mask key byte within the header
    localparam logic [3:0] MASK_OFS_SHORT = 4'd2;
    localparam logic [3:0] MASK_OFS_16    = 4'd4;
    localparam logic [3:0] MASK_OFS_64    = 4'd10;

    // tuser layout on the result side
    localparam int USER_W = 6;

    typedef struct packed {
        logic       emit;
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [3:0] frame_kind;
        logic       end_of_frame;
        logic       truncated;
    } t_dec_result;

endpackage

`default_nettype wire

### hw/rtl/websocket_frame_unmasker_unit.sv
// Pipeline: an input transaction goes into the input register, then is parsed and
//   unmasked into the result register that drives the master side.
// Throughput: 1 byte per cycle, back to back; with both registers full, slave tready
//   follows master tready, so a stalled result holds the input.
// Reset: synchronous, active low; clears both valid flags and the parser state.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_unmasker_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // slave side: received frame bytes
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [7:0]                 i_s_axis_tdata,   // [7:0] frame_byte
    input  wire logic                       i_s_axis_tlast,   // frame_end
    // master side: decoded results
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic [7:0]                      o_m_axis_tdata,   // [7:0] payload_byte
    // [0] payload_valid, [4:1] frame_kind, [5] truncated
    output logic [wfu_pkg::USER_W-1:0]      o_m_axis_tuser,
    output logic                            o_m_axis_tlast    // end_of_frame
);

    // ---------------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Result register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_pvalid;
    logic [3:0] r_out_kind;
    logic       r_out_eof;
    logic       r_out_trunc;

    logic                 in_xact;
    logic                 out_free;
    logic                 step;
    wfu_pkg::t_dec_result dec_res;

    // The held byte advances whenever the result register can take a new
    // entry; bytes that produce no result advance all the same.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || step;
    assign in_xact         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // ---------------------------------------------------------------------
    // Frame parser and unmask
    // ---------------------------------------------------------------------
    wfu_decoder u_decoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (dec_res)
    );

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= dec_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && dec_res.emit) begin
            r_out_byte   <= dec_res.payload_byte;
            r_out_pvalid <= dec_res.payload_valid;
            r_out_kind   <= dec_res.frame_kind;
            r_out_eof    <= dec_res.end_of_frame;
            r_out_trunc  <= dec_res.truncated;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = {r_out_trunc, r_out_kind, r_out_pvalid};
    assign o_m_axis_tlast  = r_out_eof;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // Unmasked data only ever comes from a text frame with a complete header.
    a_payload_is_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_pvalid) |-> (r_out_kind == wfu_pkg::KIND_TEXT && !r_out_trunc))
        else $error("payload result without text kind");

    // A truncated header is only reported on the frame's last byte.
    a_trunc_is_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_trunc) |-> r_out_eof)
        else $error("truncated result without end of frame");

    // A held byte with a stalled result register must block the slave side.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while pipeline stalled");

    // No result shows up right out of reset.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

### hw/rtl/wfu_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-byte frame parser: header walk, key capture, payload unmask.
module wfu_decoder (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_last,
    output wfu_pkg::t_dec_result      o_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEADER,
        ST_DATA,
        ST_DISCARD
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [3:0]  r_hdr_pos,  n_hdr_pos;
    logic [3:0]  r_mask_ofs, n_mask_ofs;
    logic [1:0]  r_key_idx,  n_key_idx;
    logic [31:0] r_mask_key;

    logic        key_wr;
    logic        key_done;
    logic [3:0]  key_diff;
    logic [7:0]  len_code;
    logic [7:0]  key_byte;

    assign key_diff = r_hdr_pos - r_mask_ofs;
    assign len_code = i_byte & wfu_pkg::LEN_CODE_MASK;
    assign key_byte = r_mask_key[{r_key_idx, 3'b000} +: 8];

    always_comb begin
        n_phase    = r_phase;
        n_hdr_pos  = r_hdr_pos;
        n_mask_ofs = r_mask_ofs;
        n_key_idx  = r_key_idx;
        key_wr     = 1'b0;
        key_done   = 1'b0;
        o_result   = '0;

        case (r_phase)
            ST_IDLE: begin
                if (i_byte == wfu_pkg::OPC_TEXT_FINAL) begin
                    if (i_last) begin
                        o_result.emit         = 1'b1;
                        o_result.frame_kind   = wfu_pkg::KIND_TEXT;
                        o_result.end_of_frame = 1'b1;
                        o_result.truncated    = 1'b1;
                    end else begin
                        n_phase   = ST_HEADER;
                        n_hdr_pos = 4'd1;
                    end
                end else begin
                    o_result.emit         = 1'b1;
                    o_result.frame_kind   = (i_byte == wfu_pkg::OPC_CLOSE_FINAL)
                                          ? wfu_pkg::KIND_CLOSE
                                          : i_byte[3:0];
                    o_result.end_of_frame = i_last;
                    if (!i_last) begin
                        n_phase = ST_DISCARD;
                    end
                end
            end
            ST_HEADER: begin
                if (r_hdr_pos == 4'd1) begin
                    if (len_code == wfu_pkg::LEN_CODE_16) begin
                        n_mask_ofs = wfu_pkg::MASK_OFS_16;
                    end else if (len_code == wfu_pkg::LEN_CODE_64) begin
                        n_mask_ofs = wfu_pkg::MASK_OFS_64;
                    end else begin
                        n_mask_ofs = wfu_pkg::MASK_OFS_SHORT;
                    end
                end else if (r_hdr_pos >= r_mask_ofs) begin
                    key_wr   = 1'b1;
                    key_done = (key_diff[1:0] == 2'd3);
                end
                n_hdr_pos = r_hdr_pos + 4'd1;
                if (key_done) begin
                    n_phase   = ST_DATA;
                    n_key_idx = 2'd0;
                end
                if (i_last) begin
                    o_result.emit         = 1'b1;
                    o_result.frame_kind   = wfu_pkg::KIND_TEXT;
                    o_result.end_of_frame = 1'b1;
                    o_result.truncated    = !key_done;
                end
            end
            ST_DATA: begin
                o_result.emit          = 1'b1;
                o_result.payload_byte  = i_byte ^ key_byte;
                o_result.payload_valid = 1'b1;
                o_result.frame_kind    = wfu_pkg::KIND_TEXT;
                o_result.end_of_frame  = i_last;
                n_key_idx              = r_key_idx + 2'd1;
            end
            ST_DISCARD: begin
                // rest of any frame other than a final text frame is dropped
            end
            default: begin
                n_phase = ST_IDLE;
            end
        endcase

        // every frame end puts the parser back to its reset state
        if (i_last) begin
            n_phase    = ST_IDLE;
            n_hdr_pos  = 4'd0;
            n_mask_ofs = wfu_pkg::MASK_OFS_SHORT;
            n_key_idx  = 2'd0;
        end

        if (!i_step) begin
            o_result.emit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ST_IDLE;
            r_hdr_pos  <= 4'd0;
            r_mask_ofs <= wfu_pkg::MASK_OFS_SHORT;
            r_key_idx  <= 2'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_hdr_pos  <= n_hdr_pos;
            r_mask_ofs <= n_mask_ofs;
            r_key_idx  <= n_key_idx;
        end
    end

    // key is always fully written before any payload byte reads it
    always_ff @(posedge i_clk) begin
        if (i_step && key_wr) begin
            r_mask_key[{key_diff[1:0], 3'b000} +: 8] <= i_byte;
        end
    end

endmodule

`default_nettype wire

### tb/sv/websocket_frame_unmasker_checker.sv
`timescale 1ns / 1ps

module websocket_frame_unmasker_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    input  wire logic                       i_s_tready,
    input  wire logic [7:0]                 i_s_tdata,
    input  wire logic                       i_s_tlast,
    input  wire logic                       i_m_tvalid,
    input  wire logic                       i_m_tready,
    input  wire logic [7:0]                 i_m_tdata,
    input  wire logic [wfu_pkg::USER_W-1:0] i_m_tuser,
    input  wire logic                       i_m_tlast,
    output int                              o_mismatch_count,
    output int                              o_pending
);

    typedef enum logic [1:0] {
        FRM_IDLE,
        FRM_HEADER,
        FRM_PAYLOAD,
        FRM_SKIP
    } t_frame_state;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [3:0] frame_kind;
        logic       end_of_frame;
        logic       truncated;
    } t_unmask_result;

    t_frame_state   frm_state;
    logic [3:0]     hdr_pos;
    logic [3:0]     key_start;
    logic [31:0]    mask_key;
    logic [1:0]     key_sel;
    t_unmask_result decoded_q[$];

    task automatic restart_frame();
        frm_state = FRM_IDLE;
        hdr_pos   = 4'd0;
        key_start = wfu_pkg::MASK_OFS_SHORT;
        mask_key  = 32'd0;
        key_sel   = 2'd0;
    endtask

    // One received byte in, at most one decoded result queued.
    task automatic unmask_byte(input logic [7:0] b, input logic last);
        t_unmask_result r;
        logic           produce;
        logic           key_done;
        logic [7:0]     lcode;
        logic [7:0]     nibble;
        logic [3:0]     rel;
        r        = '0;
        produce  = 1'b0;
        key_done = 1'b0;
        case (frm_state)
            FRM_IDLE: begin
                if (b == wfu_pkg::OPC_TEXT_FINAL) begin
                    if (last) begin
                        r.frame_kind   = wfu_pkg::KIND_TEXT;
                        r.end_of_frame = 1'b1;
                        r.truncated    = 1'b1;
                        produce        = 1'b1;
                    end else begin
                        frm_state = FRM_HEADER;
                        hdr_pos   = 4'd1;
                    end
                end else begin
                    nibble         = b & wfu_pkg::OPC_NIBBLE_MASK;
                    r.frame_kind   = (b == wfu_pkg::OPC_CLOSE_FINAL) ? wfu_pkg::KIND_CLOSE
                                                                     : nibble[3:0];
                    r.end_of_frame = last;
                    produce        = 1'b1;
                    if (!last) frm_state = FRM_SKIP;
                end
            end
            FRM_HEADER: begin
                if (hdr_pos == 4'd1) begin
                    lcode     = b & wfu_pkg::LEN_CODE_MASK;
                    key_start = (lcode == wfu_pkg::LEN_CODE_16) ? wfu_pkg::MASK_OFS_16 :
                                (lcode == wfu_pkg::LEN_CODE_64) ? wfu_pkg::MASK_OFS_64 :
                                                                  wfu_pkg::MASK_OFS_SHORT;
                end else if (hdr_pos >= key_start) begin
                    rel = hdr_pos - key_start;
                    mask_key[8*rel[1:0] +: 8] = b;
                    key_done = (rel[1:0] == 2'd3);
                end
                hdr_pos = hdr_pos + 4'd1;
                if (key_done) begin
                    frm_state = FRM_PAYLOAD;
                    key_sel   = 2'd0;
                end
                if (last) begin
                    r.frame_kind   = wfu_pkg::KIND_TEXT;
                    r.end_of_frame = 1'b1;
                    r.truncated    = !key_done;
                    produce        = 1'b1;
                end
            end
            FRM_PAYLOAD: begin
                r.payload_byte  = b ^ mask_key[8*key_sel +: 8];
                r.payload_valid = 1'b1;
                r.frame_kind    = wfu_pkg::KIND_TEXT;
                r.end_of_frame  = last;
                produce         = 1'b1;
                key_sel         = key_sel + 2'd1;
            end
            default: ;
        endcase
        if (last) restart_frame();
        if (produce) decoded_q.push_back(r);
    endtask

    task automatic note_mismatch(input string what, input t_unmask_result want,
                                 input t_unmask_result got);
        if (o_mismatch_count < 10) begin
            $display("%0t ns: %s: exp byte=%02h valid=%0d kind=%0d eof=%0d trunc=%0d",
                     $time, what, want.payload_byte, want.payload_valid, want.frame_kind,
                     want.end_of_frame, want.truncated);
            $display("    got byte=%02h valid=%0d kind=%0d eof=%0d trunc=%0d",
                     got.payload_byte, got.payload_valid, got.frame_kind,
                     got.end_of_frame, got.truncated);
        end
        o_mismatch_count++;
    endtask

    // Result side is checked before the input side so that a result can never
    // be matched against an expectation created in the same cycle.
    always @(posedge i_clk) begin : watch
        t_unmask_result got;
        t_unmask_result want;
        if (!i_rst_n) begin
            restart_frame();
            decoded_q.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.payload_byte  = i_m_tdata;
                got.payload_valid = i_m_tuser[0];
                got.frame_kind    = i_m_tuser[4:1];
                got.truncated     = i_m_tuser[5];
                got.end_of_frame  = i_m_tlast;
                if (decoded_q.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = decoded_q.pop_front();
                    if (got.payload_byte !== want.payload_byte ||
                        got.payload_valid !== want.payload_valid ||
                        got.frame_kind !== want.frame_kind ||
                        got.end_of_frame !== want.end_of_frame ||
                        got.truncated !== want.truncated)
                        note_mismatch("result mismatch", want, got);
                end
            end
            if (i_s_tvalid && i_s_tready)
                unmask_byte(i_s_tdata, i_s_tlast);
        end
        o_pending = decoded_q.size();
    end

endmodule

### tb/sv/websocket_frame_unmasker_unit_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the frame unmasker. Frames go in byte by byte on
// the slave stream; the checker instance beside the DUT predicts every decoded
// result and compares it with what comes out of the master stream.
module websocket_frame_unmasker_unit_tb;

    localparam int CLK_HALF       = 6;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int ITEMS_PER_MODE = 225;

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [7:0]                 s_tdata  = 8'd0;     // [7:0] frame_byte
    logic                       s_tlast  = 1'b0;     // frame_end
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [7:0]                 m_tdata;             // [7:0] payload_byte
    // [0] payload_valid, [4:1] frame_kind, [5] truncated
    logic [wfu_pkg::USER_W-1:0] m_tuser;
    logic                       m_tlast;             // end_of_frame

    int                mismatch_count;
    int                pending;
    int                bytes_sent     = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    logic [7:0]        frame_buf[$];

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    websocket_frame_unmasker_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    websocket_frame_unmasker_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_s_tlast        (s_tlast),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tuser        (m_tuser),
        .i_m_tlast        (m_tlast),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    function automatic bit chance(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // Receiver backpressure, re-rolled on every falling edge.
    always @(negedge clk) begin
        if (rst_n) m_tready <= !chance(recv_stall_pct);
    end

    // Drive one byte at the falling edge and hold it until the transaction
    // completes. Valid stays high straight into the next byte unless the
    // sender decides to idle.
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while (chance(send_idle_pct)) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    // Send frame_buf as one frame, tlast on its final byte.
    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        frame_buf.delete();
    endtask

    // Stop sending and hold off until every predicted result has come out or DRAIN_LIMIT runs out.
    task automatic drain();
        int waited;
        waited = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
    endtask

    // Mostly well-formed text frames with all three length encodings and
    // random keys; the rest are other opcodes with junk tails and text frames
    // cut off somewhere inside the header.
    task automatic send_random_frame();
        int         sel;
        int         len_sel;
        int         ext_bytes;
        int         payload_len;
        int         tail_len;
        int         cut;
        logic [7:0] first;
        logic [6:0] len_code;
        sel = $urandom_range(99, 0);
        if (sel < 12) begin
            first = 8'($urandom_range(255, 0));
            if (first == wfu_pkg::OPC_TEXT_FINAL || $urandom_range(3, 0) == 0)
                first = wfu_pkg::OPC_CLOSE_FINAL;
            frame_buf.push_back(first);
            tail_len = $urandom_range(4, 0);
            repeat (tail_len) frame_buf.push_back(8'($urandom_range(255, 0)));
            send_frame();
            return;
        end
        len_sel = $urandom_range(9, 0);
        if (len_sel < 6) begin
            len_code  = 7'($urandom_range(125, 0));
            ext_bytes = 0;
        end else if (len_sel < 8) begin
            len_code  = 7'(wfu_pkg::LEN_CODE_16);
            ext_bytes = 2;
        end else begin
            len_code  = 7'(wfu_pkg::LEN_CODE_64);
            ext_bytes = 8;
        end
        frame_buf.push_back(wfu_pkg::OPC_TEXT_FINAL);
        // mask bit is random; the block takes the key either way
        frame_buf.push_back({1'($urandom_range(1, 0)), len_code});
        repeat (ext_bytes + 4) frame_buf.push_back(8'($urandom_range(255, 0)));
        if (sel < 24) begin
            // cut anywhere in the header; cutting on the last key byte is the
            // empty-payload case
            cut = $urandom_range(frame_buf.size() - 1, 0);
            while (frame_buf.size() > cut + 1) void'(frame_buf.pop_back());
        end else begin
            payload_len = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(12, 1);
            repeat (payload_len) frame_buf.push_back(8'($urandom_range(255, 0)));
        end
        send_frame();
    endtask

    initial begin
        int target;
        int waited;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames, no idling.
        // text header ending on its first byte: truncated
        frame_buf.push_back(wfu_pkg::OPC_TEXT_FINAL);
        send_frame();
        // ends inside the mask key: truncated
        frame_buf.push_back(wfu_pkg::OPC_TEXT_FINAL); frame_buf.push_back(8'h00);
        frame_buf.push_back(8'hAA); frame_buf.push_back(8'hBB); frame_buf.push_back(8'hCC);
        send_frame();
        // mask bit set, all-zero key, no payload
        frame_buf.push_back(wfu_pkg::OPC_TEXT_FINAL); frame_buf.push_back(8'h80);
        repeat (4) frame_buf.push_back(8'h00);
        send_frame();
        // mask bit clear, all-ones key, payload extremes
        frame_buf.push_back(wfu_pkg::OPC_TEXT_FINAL); frame_buf.push_back(8'h02);
        repeat (4) frame_buf.push_back(8'hFF);
        frame_buf.push_back(8'h00); frame_buf.push_back(8'hFF);
        send_frame();
        // close frame: one report, rest of the frame dropped
        frame_buf.push_back(wfu_pkg::OPC_CLOSE_FINAL); frame_buf.push_back(8'h80);
        frame_buf.push_back(8'h12);
        send_frame();
        // other opcodes as single-byte frames
        frame_buf.push_back(8'hFF);
        send_frame();
        frame_buf.push_back(8'h00);
        send_frame();
        drain();

        // Random frames under each idling mix; full drain between mixes.
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            target = bytes_sent + ITEMS_PER_MODE;
            while (bytes_sent < target) send_random_frame();
            drain();
        end

        // allow the pipeline to settle; anything late is still checked
        waited = 0;
        while (waited < 8) begin
            @(negedge clk);
            waited++;
        end
        if (mismatch_count == 0 && pending == 0)
            $display("websocket_frame_unmasker_unit test passed");
        else
            $display("websocket_frame_unmasker_unit test failed");
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("websocket_frame_unmasker_unit test failed");
        $finish;
    end

endmodule
